// ===== sv/dsl_token_scanner_macros.svh =====
// assertion macros shared by the token scanner rtl
// expects clk and rst_n in the scope of each use
`ifndef DSL_TOKEN_SCANNER_MACROS_SVH
`define DSL_TOKEN_SCANNER_MACROS_SVH

// same-cycle implication
`define DTS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dts: same-cycle check failed");

// next-cycle implication
`define DTS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dts: next-cycle check failed");

`endif

// ===== sv/dts_pkg.sv =====
// shared constants and types for the token scanner
// no dependencies
package dts_pkg;

  // fixed field widths
  localparam int KIND_W = 4;
  localparam int ERR_W  = 2;
  localparam int MANT_W = 32;
  localparam int FRAC_W = 4;
  localparam int CHAR_W = 8;

  // token kinds
  localparam logic [KIND_W-1:0] K_INT   = 4'd0;
  localparam logic [KIND_W-1:0] K_DEC   = 4'd1;
  localparam logic [KIND_W-1:0] K_IDENT = 4'd2;
  localparam logic [KIND_W-1:0] K_LPAR  = 4'd3;
  localparam logic [KIND_W-1:0] K_RPAR  = 4'd4;
  localparam logic [KIND_W-1:0] K_LBRK  = 4'd5;
  localparam logic [KIND_W-1:0] K_RBRK  = 4'd6;
  localparam logic [KIND_W-1:0] K_COMMA = 4'd7;
  localparam logic [KIND_W-1:0] K_REPL  = 4'd8;
  localparam logic [KIND_W-1:0] K_NULL  = 4'd9;
  localparam logic [KIND_W-1:0] K_END   = 4'd10;
  localparam logic [KIND_W-1:0] K_ERR   = 4'd11;

  // error codes
  localparam logic [ERR_W-1:0] E_NONE    = 2'd0;
  localparam logic [ERR_W-1:0] E_BADCHAR = 2'd1;
  localparam logic [ERR_W-1:0] E_TWOPT   = 2'd2;
  localparam logic [ERR_W-1:0] E_NOFRAC  = 2'd3;

  // characters
  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PCT    = 8'h25;
  localparam logic [CHAR_W-1:0] CH_LPAR   = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAR   = 8'h29;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2c;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2e;
  localparam logic [CHAR_W-1:0] CH_0      = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9      = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA     = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UZ     = 8'h5a;
  localparam logic [CHAR_W-1:0] CH_LBRK   = 8'h5b;
  localparam logic [CHAR_W-1:0] CH_RBRK   = 8'h5d;
  localparam logic [CHAR_W-1:0] CH_USCORE = 8'h5f;
  localparam logic [CHAR_W-1:0] CH_LA     = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LZ     = 8'h7a;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== sv/dts_front.sv =====
// scanner front end: position counters, scan mode and token classification
// depends on dts_pkg and dsl_token_scanner_macros.svh
`include "dsl_token_scanner_macros.svh"

module dts_front #(
  parameter int POSITION_BITS = 16,
  parameter int LENGTH_BITS   = 8,
  parameter int ENT_W         = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dts_pkg::CHAR_W-1:0]  in_char_code,
  input  dts_pkg::q_stat_t            q_stat,
  output logic                        push,
  output logic [ENT_W-1:0]            entry
);

  localparam int P = POSITION_BITS;
  localparam int L = LENGTH_BITS;
  localparam logic [P-1:0] PMAX     = {P{1'b1}};
  localparam logic [P-1:0] LINE_ONE = P'(1);
  localparam logic [L-1:0] LMAX     = {L{1'b1}};
  localparam logic [L-1:0] LEN_ONE  = L'(1);

  // scan modes
  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_DIGIT = 3'd1;
  localparam logic [2:0] MODE_OTHER = 3'd2;
  localparam logic [2:0] MODE_IDENT = 3'd3;
  localparam logic [2:0] MODE_REPL  = 3'd4;
  localparam logic [2:0] MODE_DEAD  = 3'd5;

  logic [2:0]                   mode_r, mode_nxt;
  logic [P-1:0]                 line_r, line_nxt, col_r, col_nxt;
  logic [P-1:0]                 sline_r, sline_nxt, scol_r, scol_nxt;
  logic [dts_pkg::MANT_W-1:0]   val_r, val_nxt;
  logic [dts_pkg::FRAC_W-1:0]   frac_r, frac_nxt;
  logic                         seen_r, seen_nxt, neg_r, neg_nxt, usc_r, usc_nxt;
  logic [L-1:0]                 len_r, len_nxt;

  logic [dts_pkg::CHAR_W-1:0]   c;
  logic                         in_fire, done;
  logic                         is_digit, is_alpha, is_name;
  logic [3:0]                   dig;
  logic [P-1:0]                 pos_line, pos_col;

  // first token: the one the byte ends
  logic                         a_vld;
  logic [dts_pkg::KIND_W-1:0]   a_kind;
  logic [dts_pkg::ERR_W-1:0]    a_err;
  logic [P-1:0]                 a_line, a_col;
  logic [dts_pkg::MANT_W-1:0]   a_mant;
  logic [dts_pkg::FRAC_W-1:0]   a_frac;
  logic [L-1:0]                 a_len;
  // second token: the one the byte forms itself
  logic                         b_vld;
  logic [dts_pkg::KIND_W-1:0]   b_kind;
  logic [dts_pkg::ERR_W-1:0]    b_err;

  logic [ENT_W/2-1:0]           tok_a, tok_b;

  assign c        = in_char_code;
  assign in_ready = !q_stat.full;
  assign in_fire  = in_valid && in_ready;
  assign dig      = c[3:0];
  assign is_digit = (c >= dts_pkg::CH_0) && (c <= dts_pkg::CH_9);
  assign is_alpha = ((c >= dts_pkg::CH_LA) && (c <= dts_pkg::CH_LZ)) ||
                    ((c >= dts_pkg::CH_UA) && (c <= dts_pkg::CH_UZ));
  assign is_name  = is_alpha || is_digit || (c == dts_pkg::CH_USCORE);

  // position update, then token logic
  always_comb begin
    pos_line = line_r;
    pos_col  = col_r;
    if (c == dts_pkg::CH_LF) begin
      if (line_r != PMAX) pos_line = line_r + LINE_ONE;
      pos_col = '0;
    end else if (col_r != PMAX) begin
      pos_col = col_r + LINE_ONE;
    end

    mode_nxt  = mode_r;
    line_nxt  = pos_line;
    col_nxt   = pos_col;
    sline_nxt = sline_r;
    scol_nxt  = scol_r;
    val_nxt   = val_r;
    frac_nxt  = frac_r;
    seen_nxt  = seen_r;
    neg_nxt   = neg_r;
    len_nxt   = len_r;
    usc_nxt   = usc_r;
    done      = 1'b0;

    a_vld  = 1'b0;
    a_kind = dts_pkg::K_INT;
    a_err  = dts_pkg::E_NONE;
    a_line = sline_r;
    a_col  = scol_r;
    a_mant = '0;
    a_frac = '0;
    a_len  = '0;
    b_vld  = 1'b0;
    b_kind = dts_pkg::K_END;
    b_err  = dts_pkg::E_NONE;

    // continue or close the open token
    if (mode_r == MODE_DIGIT || mode_r == MODE_OTHER) begin
      if (is_digit) begin
        if (seen_r && frac_r != 4'd15) frac_nxt = frac_r + 4'd1;
        val_nxt  = (val_r << 3) + (val_r << 1) + {28'd0, dig};
        mode_nxt = MODE_DIGIT;
        done     = 1'b1;
      end else if (c == dts_pkg::CH_MINUS) begin
        if (neg_r || val_r != '0) begin
          a_vld    = 1'b1;
          a_kind   = dts_pkg::K_ERR;
          a_err    = dts_pkg::E_BADCHAR;
          a_line   = pos_line;
          a_col    = pos_col;
          mode_nxt = MODE_DEAD;
        end else begin
          neg_nxt  = 1'b1;
          mode_nxt = MODE_OTHER;
          done     = 1'b1;
        end
      end else if (c == dts_pkg::CH_DOT && mode_r == MODE_DIGIT) begin
        if (seen_r) begin
          a_vld    = 1'b1;
          a_kind   = dts_pkg::K_ERR;
          a_err    = dts_pkg::E_TWOPT;
          mode_nxt = MODE_DEAD;
        end else begin
          seen_nxt = 1'b1;
          mode_nxt = MODE_OTHER;
          done     = 1'b1;
        end
      end else if (seen_r && frac_r == '0) begin
        a_vld    = 1'b1;
        a_kind   = dts_pkg::K_ERR;
        a_err    = dts_pkg::E_NOFRAC;
        mode_nxt = MODE_DEAD;
      end else begin
        a_vld    = 1'b1;
        a_kind   = seen_r ? dts_pkg::K_DEC : dts_pkg::K_INT;
        a_mant   = neg_r ? (32'd0 - val_r) : val_r;
        a_frac   = seen_r ? frac_r : 4'd0;
        mode_nxt = MODE_IDLE;
      end
    end else if (mode_r == MODE_IDENT || mode_r == MODE_REPL) begin
      if (is_name) begin
        if (len_r != LMAX) len_nxt = len_r + LEN_ONE;
        done = 1'b1;
      end else begin
        a_vld = 1'b1;
        a_len = len_r;
        if (mode_r == MODE_REPL) a_kind = dts_pkg::K_REPL;
        else if (len_r == LEN_ONE && usc_r) a_kind = dts_pkg::K_NULL;
        else a_kind = dts_pkg::K_IDENT;
        mode_nxt = MODE_IDLE;
      end
    end

    // the byte on its own
    if (!done) begin
      if (c == dts_pkg::CH_NUL) begin
        b_vld     = 1'b1;
        b_kind    = dts_pkg::K_END;
        mode_nxt  = MODE_IDLE;
        line_nxt  = LINE_ONE;
        col_nxt   = '0;
        sline_nxt = '0;
        scol_nxt  = '0;
        val_nxt   = '0;
        frac_nxt  = '0;
        seen_nxt  = 1'b0;
        neg_nxt   = 1'b0;
        len_nxt   = '0;
        usc_nxt   = 1'b0;
      end else if (mode_nxt != MODE_DEAD) begin
        mode_nxt = MODE_IDLE;
        case (c) inside
          dts_pkg::CH_SPACE, dts_pkg::CH_TAB, dts_pkg::CH_LF: begin
          end
          dts_pkg::CH_LPAR: begin
            b_vld  = 1'b1;
            b_kind = dts_pkg::K_LPAR;
          end
          dts_pkg::CH_RPAR: begin
            b_vld  = 1'b1;
            b_kind = dts_pkg::K_RPAR;
          end
          dts_pkg::CH_LBRK: begin
            b_vld  = 1'b1;
            b_kind = dts_pkg::K_LBRK;
          end
          dts_pkg::CH_RBRK: begin
            b_vld  = 1'b1;
            b_kind = dts_pkg::K_RBRK;
          end
          dts_pkg::CH_COMMA: begin
            b_vld  = 1'b1;
            b_kind = dts_pkg::K_COMMA;
          end
          dts_pkg::CH_PCT, dts_pkg::CH_MINUS, [dts_pkg::CH_0:dts_pkg::CH_9],
          [dts_pkg::CH_LA:dts_pkg::CH_LZ], [dts_pkg::CH_UA:dts_pkg::CH_UZ],
          dts_pkg::CH_USCORE: begin
            // open a new token here
            sline_nxt = pos_line;
            scol_nxt  = pos_col;
            val_nxt   = '0;
            frac_nxt  = '0;
            seen_nxt  = 1'b0;
            neg_nxt   = 1'b0;
            len_nxt   = '0;
            usc_nxt   = 1'b0;
            if (c == dts_pkg::CH_PCT) begin
              mode_nxt = MODE_REPL;
            end else if (is_digit) begin
              val_nxt  = {28'd0, dig};
              mode_nxt = MODE_DIGIT;
            end else if (c == dts_pkg::CH_MINUS) begin
              neg_nxt  = 1'b1;
              mode_nxt = MODE_OTHER;
            end else begin
              len_nxt  = LEN_ONE;
              usc_nxt  = (c == dts_pkg::CH_USCORE);
              mode_nxt = MODE_IDENT;
            end
          end
          default: begin
            b_vld    = 1'b1;
            b_kind   = dts_pkg::K_ERR;
            b_err    = dts_pkg::E_BADCHAR;
            mode_nxt = MODE_DEAD;
          end
        endcase
      end
    end
  end

  // pack the request: {two tokens, second, first}
  assign tok_a = {a_kind, a_err, a_line, a_col, a_mant, a_frac, a_len};
  assign tok_b = {b_kind, b_err, pos_line, pos_col, {dts_pkg::MANT_W{1'b0}},
                  {dts_pkg::FRAC_W{1'b0}}, {L{1'b0}}};
  assign push  = in_fire && (a_vld || b_vld);
  assign entry = {a_vld && b_vld, tok_b, a_vld ? tok_a : tok_b};

  // scanner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      line_r  <= LINE_ONE;
      col_r   <= '0;
      sline_r <= '0;
      scol_r  <= '0;
      val_r   <= '0;
      frac_r  <= '0;
      seen_r  <= 1'b0;
      neg_r   <= 1'b0;
      len_r   <= '0;
      usc_r   <= 1'b0;
    end else if (in_fire) begin
      mode_r  <= mode_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      sline_r <= sline_nxt;
      scol_r  <= scol_nxt;
      val_r   <= val_nxt;
      frac_r  <= frac_nxt;
      seen_r  <= seen_nxt;
      neg_r   <= neg_nxt;
      len_r   <= len_nxt;
      usc_r   <= usc_nxt;
    end
  end

  // checks
  `DTS_ASSERT_NXT(a_end_resets, in_fire && (in_char_code == dts_pkg::CH_NUL),
                  (mode_r == MODE_IDLE) && (line_r == LINE_ONE) && (col_r == '0))
  `DTS_ASSERT_IMP(a_dead_silent,
                  in_fire && (mode_r == MODE_DEAD) && (in_char_code != dts_pkg::CH_NUL),
                  !push)
  `DTS_ASSERT_IMP(a_push_room, push, !q_stat.full)

endmodule

// ===== sv/dts_queue.sv =====
// request queue between scanner front and token emitter
// depends on dts_pkg
module dts_queue #(
  parameter int ENT_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [ENT_W-1:0] push_data,
  input  logic             pop,
  output logic [ENT_W-1:0] head,
  output dts_pkg::q_stat_t stat
);

  logic [ENT_W-1:0]           mem [dts_pkg::QUEUE_DEPTH];
  logic [dts_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [dts_pkg::QCNT_W-1:0] count_r, count_nxt;

  assign head       = mem[rd_ptr_r];
  assign stat.full  = (count_r == dts_pkg::QCNT_W'(dts_pkg::QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);

  // occupancy
  always_comb begin
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

endmodule

// ===== sv/dts_back.sv =====
// token emitter: output register plus a slot for the second token of a byte
// depends on dts_pkg and dsl_token_scanner_macros.svh
`include "dsl_token_scanner_macros.svh"

module dts_back #(
  parameter int POSITION_BITS = 16,
  parameter int LENGTH_BITS   = 8,
  parameter int ENT_W         = 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [ENT_W-1:0]             head,
  input  dts_pkg::q_stat_t             q_stat,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dts_pkg::KIND_W-1:0]   out_token_kind,
  output logic [dts_pkg::ERR_W-1:0]    out_error_code,
  output logic [POSITION_BITS-1:0]     out_token_line,
  output logic [POSITION_BITS-1:0]     out_token_column,
  output logic signed [dts_pkg::MANT_W-1:0] out_mantissa,
  output logic [dts_pkg::FRAC_W-1:0]   out_fraction_digits,
  output logic [LENGTH_BITS-1:0]       out_lexeme_length,
  output logic                         out_last_of_run
);

  localparam int P     = POSITION_BITS;
  localparam int L     = LENGTH_BITS;
  localparam int TOK_W = (ENT_W - 1) / 2;
  // field offsets inside one token
  localparam int O_LEN  = 0;
  localparam int O_FRAC = O_LEN + L;
  localparam int O_MANT = O_FRAC + dts_pkg::FRAC_W;
  localparam int O_COL  = O_MANT + dts_pkg::MANT_W;
  localparam int O_LINE = O_COL + P;
  localparam int O_ERR  = O_LINE + P;
  localparam int O_KIND = O_ERR + dts_pkg::ERR_W;

  logic             out_valid_r, sec_valid_r, last_r;
  logic [TOK_W-1:0] tok_r, sec_r;
  logic             load, two;

  assign two   = head[ENT_W-1];
  assign load  = !out_valid_r || out_ready;
  assign q_pop = load && !sec_valid_r && !q_stat.empty;

  // output valid and pending second token
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sec_valid_r <= 1'b0;
    end else if (load) begin
      if (sec_valid_r) begin
        out_valid_r <= 1'b1;
        sec_valid_r <= 1'b0;
      end else if (!q_stat.empty) begin
        out_valid_r <= 1'b1;
        sec_valid_r <= two;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // token payload
  always_ff @(posedge clk) begin
    if (load) begin
      if (sec_valid_r) begin
        tok_r  <= sec_r;
        last_r <= 1'b1;
      end else if (!q_stat.empty) begin
        tok_r  <= head[TOK_W-1:0];
        sec_r  <= head[2*TOK_W-1:TOK_W];
        last_r <= !two;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_token_kind      = tok_r[O_KIND +: dts_pkg::KIND_W];
  assign out_error_code      = tok_r[O_ERR +: dts_pkg::ERR_W];
  assign out_token_line      = tok_r[O_LINE +: P];
  assign out_token_column    = tok_r[O_COL +: P];
  assign out_mantissa        = tok_r[O_MANT +: dts_pkg::MANT_W];
  assign out_fraction_digits = tok_r[O_FRAC +: dts_pkg::FRAC_W];
  assign out_lexeme_length   = tok_r[O_LEN +: L];
  assign out_last_of_run     = last_r;

  // checks
  `DTS_ASSERT_IMP(a_sec_shown, sec_valid_r, out_valid_r)
  `DTS_ASSERT_IMP(a_pop_nonempty, q_pop, !q_stat.empty && !sec_valid_r)
  `DTS_ASSERT_NXT(a_drain, out_valid_r && out_ready && !sec_valid_r && q_stat.empty,
                  !out_valid_r)

endmodule

// ===== sv/dsl_token_scanner.sv =====
// token scanner for a small effect language, top level
// depends on dts_pkg, dts_front, dts_queue and dts_back
//
// Usage: one character byte per request on the in_ channel; a zero byte
// ends the text and emits an end token. Tokens leave on the out_ channel,
// one per request, with last_of_run set on the final token a byte causes.
// A number, name or replacement is known only when the byte after it
// arrives, so one byte can cause two tokens, which leave one after the other.
// Path: the front classifies a byte combinationally and writes the queue
// when the byte is accepted; the back end loads its output register from
// the queue head, and a second token from the same byte follows from its slot.
// Throughput: one byte per cycle while the queue has room; the front's
// combinational classify and times-ten accumulate allow it. The output side
// drains one token per cycle while out_ready is high, bounding two-token runs.
// Reset: synchronous, active low; line starts at 1, column at 0, queue
// and output empty.
// Stall: when out_ready is low the output holds; the four-entry queue
// absorbs bytes until full, then in_ready drops.
module dsl_token_scanner #(
  parameter int POSITION_BITS = 16,
  parameter int LENGTH_BITS   = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [dts_pkg::CHAR_W-1:0]        in_char_code,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dts_pkg::KIND_W-1:0]        out_token_kind,
  output logic [dts_pkg::ERR_W-1:0]         out_error_code,
  output logic [POSITION_BITS-1:0]          out_token_line,
  output logic [POSITION_BITS-1:0]          out_token_column,
  output logic signed [dts_pkg::MANT_W-1:0] out_mantissa,
  output logic [dts_pkg::FRAC_W-1:0]        out_fraction_digits,
  output logic [LENGTH_BITS-1:0]            out_lexeme_length,
  output logic                              out_last_of_run
);

  localparam int TOK_W = dts_pkg::KIND_W + dts_pkg::ERR_W + 2 * POSITION_BITS +
                         dts_pkg::MANT_W + dts_pkg::FRAC_W + LENGTH_BITS;
  localparam int ENT_W = 1 + 2 * TOK_W;

  dts_pkg::q_stat_t q_stat;
  logic             push, q_pop;
  logic [ENT_W-1:0] entry, head;

  dts_front #(
    .POSITION_BITS (POSITION_BITS),
    .LENGTH_BITS   (LENGTH_BITS),
    .ENT_W         (ENT_W)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_code (in_char_code),
    .q_stat       (q_stat),
    .push         (push),
    .entry        (entry)
  );

  dts_queue #(
    .ENT_W (ENT_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (entry),
    .pop       (q_pop),
    .head      (head),
    .stat      (q_stat)
  );

  dts_back #(
    .POSITION_BITS (POSITION_BITS),
    .LENGTH_BITS   (LENGTH_BITS),
    .ENT_W         (ENT_W)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head                (head),
    .q_stat              (q_stat),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_token_kind      (out_token_kind),
    .out_error_code      (out_error_code),
    .out_token_line      (out_token_line),
    .out_token_column    (out_token_column),
    .out_mantissa        (out_mantissa),
    .out_fraction_digits (out_fraction_digits),
    .out_lexeme_length   (out_lexeme_length),
    .out_last_of_run     (out_last_of_run)
  );

endmodule

// ===== bench/dsl_token_scanner_tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for the dsl_token_scanner character-to-token block
// depends on dts_pkg and dsl_token_scanner; carries its own token predictor
module dsl_token_scanner_tb;

  localparam int CHAR_W = dts_pkg::CHAR_W;
  localparam int KIND_W = dts_pkg::KIND_W;
  localparam int ERR_W = dts_pkg::ERR_W;
  localparam int MANT_W = dts_pkg::MANT_W;
  localparam int FRAC_W = dts_pkg::FRAC_W;
  localparam int POS_W = 16;
  localparam int LEN_W = 8;
  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;
  localparam logic [FRAC_W-1:0] FRAC_MAX = '1;
  localparam logic [8:0] DRAIN_MARK = 9'h100;
  localparam int IDLE_PCT = 12;
  localparam int CALM_FROM = 400;
  localparam int CALM_TO = 560;
  localparam int HOLD_AT = 150;
  localparam int HOLD_LEN = 400;
  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_ITEMS = 360;

  typedef enum logic [2:0] {
    LX_IDLE, LX_NUM_DIGIT, LX_NUM_OTHER, LX_IDENT, LX_REPL, LX_DEAD
  } lex_mode_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ERR_W-1:0]  err;
    logic [POS_W-1:0]  tline;
    logic [POS_W-1:0]  tcol;
    logic [MANT_W-1:0] mant;
    logic [FRAC_W-1:0] frac;
    logic [LEN_W-1:0]  len;
    logic              last;
  } token_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CHAR_W-1:0] in_char_code = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [KIND_W-1:0] out_token_kind;
  logic [ERR_W-1:0] out_error_code;
  logic [POS_W-1:0] out_token_line;
  logic [POS_W-1:0] out_token_column;
  logic signed [MANT_W-1:0] out_mantissa;
  logic [FRAC_W-1:0] out_fraction_digits;
  logic [LEN_W-1:0] out_lexeme_length;
  logic out_last_of_run;

  dsl_token_scanner #(
    .POSITION_BITS(POS_W),
    .LENGTH_BITS(LEN_W)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_char_code(in_char_code),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_token_kind(out_token_kind),
    .out_error_code(out_error_code),
    .out_token_line(out_token_line),
    .out_token_column(out_token_column),
    .out_mantissa(out_mantissa),
    .out_fraction_digits(out_fraction_digits),
    .out_lexeme_length(out_lexeme_length),
    .out_last_of_run(out_last_of_run)
  );

  // characters still to send, with drain markers between phases
  logic [8:0] char_queue[$];
  logic [8:0] next_req;
  // tokens predicted but not yet seen on the output
  token_t tokens_due[$];
  token_t run_toks[$];
  token_t seen_tok;
  token_t want_tok;
  int fed_cnt = 0;
  int mismatches = 0;
  int quiet = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  logic calm;

  // scanner state mirrored by the predictor
  lex_mode_t lex_mode;
  logic [POS_W-1:0] cur_line, cur_col, tok_line, tok_col;
  logic [MANT_W-1:0] acc;
  logic [FRAC_W-1:0] frac_n;
  logic has_point, neg, only_us;
  logic [LEN_W-1:0] name_len;

  assign calm = (fed_cnt >= CALM_FROM) && (fed_cnt < CALM_TO);

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic bit is_digit(input logic [CHAR_W-1:0] c);
    return c >= dts_pkg::CH_0 && c <= dts_pkg::CH_9;
  endfunction

  function automatic bit is_alpha(input logic [CHAR_W-1:0] c);
    return (c >= dts_pkg::CH_LA && c <= dts_pkg::CH_LZ) ||
           (c >= dts_pkg::CH_UA && c <= dts_pkg::CH_UZ);
  endfunction

  function automatic void clear_lexeme();
    acc = '0;
    frac_n = '0;
    has_point = 1'b0;
    neg = 1'b0;
    name_len = '0;
    only_us = 1'b0;
  endfunction

  function automatic void scanner_reset();
    lex_mode = LX_IDLE;
    cur_line = POS_W'(1);
    cur_col = '0;
    tok_line = '0;
    tok_col = '0;
    clear_lexeme();
  endfunction

  function automatic void mark_start();
    tok_line = cur_line;
    tok_col = cur_col;
    clear_lexeme();
  endfunction

  function automatic void emit(input logic [KIND_W-1:0] kind, input logic [ERR_W-1:0] err,
                               input logic [POS_W-1:0] l, input logic [POS_W-1:0] c,
                               input logic [MANT_W-1:0] m, input logic [FRAC_W-1:0] f,
                               input logic [LEN_W-1:0] n);
    token_t t;
    t.kind = kind;
    t.err = err;
    t.tline = l;
    t.tcol = c;
    t.mant = m;
    t.frac = f;
    t.len = n;
    t.last = 1'b0;
    run_toks.insert(run_toks.size(), t);
  endfunction

  // predict the tokens one accepted character causes
  function automatic void scan_char(input logic [CHAR_W-1:0] c);
    bit absorbed;
    token_t t;
    absorbed = 1'b0;
    run_toks.delete();

    // position moves on every byte, saturating
    if (c == dts_pkg::CH_LF) begin
      if (cur_line != POS_MAX) cur_line++;
      cur_col = '0;
    end else if (cur_col != POS_MAX) begin
      cur_col++;
    end

    // close or extend a token in progress
    if (lex_mode == LX_NUM_DIGIT || lex_mode == LX_NUM_OTHER) begin
      if (is_digit(c)) begin
        if (has_point && frac_n != FRAC_MAX) frac_n++;
        acc = acc * MANT_W'(10) + MANT_W'(c - dts_pkg::CH_0);
        lex_mode = LX_NUM_DIGIT;
        absorbed = 1'b1;
      end else if (c == dts_pkg::CH_MINUS) begin
        if (neg || acc != '0) begin
          emit(dts_pkg::K_ERR, dts_pkg::E_BADCHAR, cur_line, cur_col, '0, '0, '0);
          lex_mode = LX_DEAD;
        end else begin
          neg = 1'b1;
          lex_mode = LX_NUM_OTHER;
          absorbed = 1'b1;
        end
      end else if (c == dts_pkg::CH_DOT && lex_mode == LX_NUM_DIGIT) begin
        if (has_point) begin
          emit(dts_pkg::K_ERR, dts_pkg::E_TWOPT, tok_line, tok_col, '0, '0, '0);
          lex_mode = LX_DEAD;
        end else begin
          has_point = 1'b1;
          lex_mode = LX_NUM_OTHER;
          absorbed = 1'b1;
        end
      end else if (has_point && frac_n == '0) begin
        emit(dts_pkg::K_ERR, dts_pkg::E_NOFRAC, tok_line, tok_col, '0, '0, '0);
        lex_mode = LX_DEAD;
      end else begin
        emit(has_point ? dts_pkg::K_DEC : dts_pkg::K_INT, dts_pkg::E_NONE,
             tok_line, tok_col, neg ? ('0 - acc) : acc, has_point ? frac_n : '0, '0);
        lex_mode = LX_IDLE;
      end
    end else if (lex_mode == LX_IDENT || lex_mode == LX_REPL) begin
      if (is_alpha(c) || is_digit(c) || c == dts_pkg::CH_USCORE) begin
        if (name_len != LEN_MAX) name_len++;
        absorbed = 1'b1;
      end else begin
        if (lex_mode == LX_REPL)
          emit(dts_pkg::K_REPL, dts_pkg::E_NONE, tok_line, tok_col, '0, '0, name_len);
        else if (name_len == LEN_W'(1) && only_us)
          emit(dts_pkg::K_NULL, dts_pkg::E_NONE, tok_line, tok_col, '0, '0, name_len);
        else
          emit(dts_pkg::K_IDENT, dts_pkg::E_NONE, tok_line, tok_col, '0, '0, name_len);
        lex_mode = LX_IDLE;
      end
    end

    // the byte itself: end of text, a mark, or the start of a token
    if (!absorbed) begin
      if (c == dts_pkg::CH_NUL) begin
        emit(dts_pkg::K_END, dts_pkg::E_NONE, cur_line, cur_col, '0, '0, '0);
        scanner_reset();
      end else if (lex_mode != LX_DEAD) begin
        lex_mode = LX_IDLE;
        case (c)
          dts_pkg::CH_SPACE, dts_pkg::CH_TAB, dts_pkg::CH_LF: ;
          dts_pkg::CH_LPAR:
            emit(dts_pkg::K_LPAR, dts_pkg::E_NONE, cur_line, cur_col, '0, '0, '0);
          dts_pkg::CH_RPAR:
            emit(dts_pkg::K_RPAR, dts_pkg::E_NONE, cur_line, cur_col, '0, '0, '0);
          dts_pkg::CH_LBRK:
            emit(dts_pkg::K_LBRK, dts_pkg::E_NONE, cur_line, cur_col, '0, '0, '0);
          dts_pkg::CH_RBRK:
            emit(dts_pkg::K_RBRK, dts_pkg::E_NONE, cur_line, cur_col, '0, '0, '0);
          dts_pkg::CH_COMMA:
            emit(dts_pkg::K_COMMA, dts_pkg::E_NONE, cur_line, cur_col, '0, '0, '0);
          dts_pkg::CH_PCT: begin
            mark_start();
            lex_mode = LX_REPL;
          end
          dts_pkg::CH_MINUS: begin
            mark_start();
            neg = 1'b1;
            lex_mode = LX_NUM_OTHER;
          end
          default: begin
            if (is_digit(c)) begin
              mark_start();
              acc = MANT_W'(c - dts_pkg::CH_0);
              lex_mode = LX_NUM_DIGIT;
            end else if (is_alpha(c) || c == dts_pkg::CH_USCORE) begin
              mark_start();
              name_len = LEN_W'(1);
              only_us = (c == dts_pkg::CH_USCORE);
              lex_mode = LX_IDENT;
            end else begin
              emit(dts_pkg::K_ERR, dts_pkg::E_BADCHAR, cur_line, cur_col, '0, '0, '0);
              lex_mode = LX_DEAD;
            end
          end
        endcase
      end
    end

    // flag the final token of this byte and queue them all
    foreach (run_toks[i]) begin
      t = run_toks[i];
      t.last = (i == run_toks.size() - 1);
      tokens_due.insert(tokens_due.size(), t);
    end
  endfunction

  function automatic string tok_str(input token_t t);
    return $sformatf("kind %0d err %0d line %0d col %0d mant %0d frac %0d len %0d last %0b",
                     t.kind, t.err, t.tline, t.tcol, $signed(t.mant), t.frac, t.len, t.last);
  endfunction

  // stimulus builders
  function automatic void put_byte(input logic [CHAR_W-1:0] b);
    char_queue.insert(char_queue.size(), {1'b0, b});
  endfunction

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  function automatic void put_digits(input int n);
    repeat (n) put_byte(dts_pkg::CH_0 + CHAR_W'($urandom_range(9)));
  endfunction

  function automatic void put_name_chars(input int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(62);
      if (k < 26) put_byte(dts_pkg::CH_LA + CHAR_W'(k));
      else if (k < 52) put_byte(dts_pkg::CH_UA + CHAR_W'(k - 26));
      else if (k < 62) put_byte(dts_pkg::CH_0 + CHAR_W'(k - 52));
      else put_byte(dts_pkg::CH_USCORE);
    end
  endfunction

  function automatic void put_whitespace();
    case ($urandom_range(2))
      0: put_byte(dts_pkg::CH_SPACE);
      1: put_byte(dts_pkg::CH_TAB);
      default: put_byte(dts_pkg::CH_LF);
    endcase
  endfunction

  // one text of well-formed tokens, possibly cut short by a broken number or noise
  function automatic void put_random_text();
    int ntok, pick;
    ntok = $urandom_range(2, 14);
    for (int t = 0; t < ntok; t++) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        if ($urandom_range(3) == 0) put_byte(dts_pkg::CH_MINUS);
        put_digits(($urandom_range(9) == 0) ? $urandom_range(11, 14) : $urandom_range(1, 4));
        if ($urandom_range(2) == 0) begin
          put_byte(dts_pkg::CH_DOT);
          put_digits(($urandom_range(7) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 4));
        end
      end else if (pick < 45) begin
        if ($urandom_range(9) == 0) begin
          put_byte(dts_pkg::CH_USCORE);
        end else begin
          put_byte(($urandom_range(5) == 0) ? dts_pkg::CH_USCORE :
                   dts_pkg::CH_LA + CHAR_W'($urandom_range(25)));
          put_name_chars($urandom_range(0, 7));
        end
      end else if (pick < 55) begin
        put_byte(dts_pkg::CH_PCT);
        put_name_chars($urandom_range(0, 6));
      end else if (pick < 80) begin
        case ($urandom_range(4))
          0: put_byte(dts_pkg::CH_LPAR);
          1: put_byte(dts_pkg::CH_RPAR);
          2: put_byte(dts_pkg::CH_LBRK);
          3: put_byte(dts_pkg::CH_RBRK);
          default: put_byte(dts_pkg::CH_COMMA);
        endcase
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 3)) put_whitespace();
      end else if (pick < 95) begin
        case ($urandom_range(5))
          0: put_text("1..");
          1: put_text("12.3.");
          2: put_text("4-");
          3: put_text("-.");
          4: put_text("7.");
          default: put_text("0-5-");
        endcase
        break;
      end else begin
        put_byte(CHAR_W'($urandom_range(1, 255)));
        break;
      end
      if ($urandom_range(9) < 6) put_whitespace();
    end
    put_byte(dts_pkg::CH_NUL);
  endfunction

  // request driver: predicts each accepted character, then offers the next
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      scanner_reset();
    end else begin
      if (in_valid && in_ready) begin
        scan_char(in_char_code);
        fed_cnt++;
      end
      if (!in_valid || in_ready) begin
        // sender pause until the output has caught up
        if (char_queue.size() != 0 && char_queue[0] == DRAIN_MARK && tokens_due.size() == 0)
          void'(char_queue.pop_front());
        if (char_queue.size() != 0 && char_queue[0] != DRAIN_MARK &&
            (calm || $urandom_range(99) >= IDLE_PCT)) begin
          next_req = char_queue.pop_front();
          in_valid <= 1'b1;
          in_char_code <= next_req[CHAR_W-1:0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output ready: random stalls, one long hold-off to back up the input
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && fed_cnt >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // token monitor and compare
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_tok = '{kind: out_token_kind, err: out_error_code, tline: out_token_line,
                   tcol: out_token_column, mant: out_mantissa, frac: out_fraction_digits,
                   len: out_lexeme_length, last: out_last_of_run};
      if (tokens_due.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: token with none expected: %s", $realtime, tok_str(seen_tok));
        mismatches++;
      end else begin
        want_tok = tokens_due.pop_front();
        if (seen_tok !== want_tok) begin
          if (mismatches < MAX_REPORTS) begin
            $display("%0t: token mismatch", $realtime);
            $display("  expected %s", tok_str(want_tok));
            $display("  actual   %s", tok_str(seen_tok));
          end
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no request moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", quiet);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // stimulus build, reset and end of run
  initial begin
    int target;
    // directed: every token kind, every error, dead mode, empty replacement, lone minus
    put_text("-1.5,_ x[%a)%]-(\n7.");
    put_byte(dts_pkg::CH_NUL);
    put_text("1.2.");
    put_byte(8'hff);
    put_byte(dts_pkg::CH_NUL);
    put_text("9-");
    put_byte(dts_pkg::CH_NUL);
    put_byte(8'h0d);
    put_byte(dts_pkg::CH_NUL);
    char_queue.insert(char_queue.size(), DRAIN_MARK);

    // random texts, with a pause for the output halfway through
    target = char_queue.size() + RANDOM_ITEMS / 2;
    while (char_queue.size() < target) put_random_text();
    char_queue.insert(char_queue.size(), DRAIN_MARK);
    target = char_queue.size() + RANDOM_ITEMS / 2;
    while (char_queue.size() < target) put_random_text();
    char_queue.insert(char_queue.size(), DRAIN_MARK);

    // saturation: replacement length, wrapping mantissa, fraction count
    put_byte(dts_pkg::CH_PCT);
    repeat (258) put_byte(dts_pkg::CH_LA);
    put_byte(dts_pkg::CH_SPACE);
    put_text("Zq_9");
    put_byte(dts_pkg::CH_COMMA);
    repeat (25) put_byte(dts_pkg::CH_9);
    put_byte(dts_pkg::CH_DOT);
    put_digits(20);
    put_byte(dts_pkg::CH_SPACE);
    put_byte(dts_pkg::CH_LPAR);
    put_byte(dts_pkg::CH_LF);
    put_byte(dts_pkg::CH_RPAR);
    put_byte(dts_pkg::CH_NUL);
    put_text("(_");
    put_byte(dts_pkg::CH_NUL);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    while (char_queue.size() != 0 || in_valid) @(posedge clk);
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && tokens_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/dts_pkg.sv
sv/dts_front.sv
sv/dts_queue.sv
sv/dts_back.sv
sv/dsl_token_scanner.sv
bench/dsl_token_scanner_tb.sv
